/* hdl/arl_pkg.sv */
`timescale 1ns / 1ps

package arl_pkg;

   // operation codes
   localparam logic [1:0] OP_SET     = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_PROCESS = 2'd2;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   // status codes
   localparam logic [2:0] STAT_UPDATED   = 3'd0;
   localparam logic [2:0] STAT_INSERTED  = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_CLEARED   = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [2:0] STAT_DONE      = 3'd5;

   // csr register indexes
   localparam int         CSR_INDEX_W        = 8;
   localparam logic [7:0] CSR_MAX_SEND_COUNT = 8'd0;
   localparam logic [7:0] CSR_REPEAT_LATENCY = 8'd1;

   localparam logic [7:0]  MAX_SEND_COUNT_RESET = 8'd3;
   localparam logic [31:0] REPEAT_LATENCY_RESET = 32'd600000;

   // notices per process transaction
   localparam logic [4:0] MAX_NOTICES = 5'd16;

   // action mask bits
   localparam int ACT_SMS_BIT   = 0;
   localparam int ACT_EMAIL_BIT = 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // one table entry as held in memory
   typedef struct packed {
      logic [63:0] key;
      logic [7:0]  endpoint;
      logic [15:0] cluster;
      logic [15:0] attribute;
      logic [1:0]  action;
      logic        on;
      logic [7:0]  send_count;
      logic [31:0] last_sent;
      logic        ever_sent;
   } rec_type;

   // one result transaction
   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [63:0] alarm_addr;
      logic [7:0]  alarm_endpoint;
      logic [15:0] alarm_cluster;
      logic [15:0] alarm_attribute;
      logic        send_sms;
      logic        send_email;
      logic [7:0]  sent_number;
      logic        last;
   } res_type;

endpackage

/* hdl/arl_ram.sv */
`timescale 1ns / 1ps

module arl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/alarm_repeat_limiter_table.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// req_      in         req_valid / req_ready     op, key fields, action mask, now tick
// rsp_      out        rsp_valid / rsp_ready     kind, status, slot, notice fields, last
// csr_      in         csr_valid / csr_ready     csr_index, csr_data
//
// one request transaction at a time; the table walk reads one entry per cycle from
// the single read port of the entry memory, except while an emitted result holds it
// reset clears the fill count, the walk counters and the control state, and loads the csr
// registers with their reset values; the payload registers and memory are not cleared
// a result that waits in the output register stalls the walk, not the next request accept
// csr writes are always taken

module alarm_repeat_limiter_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [63:0]                        req_device_addr,
   input  logic [7:0]                         req_endpoint,
   input  logic [15:0]                        req_cluster,
   input  logic [15:0]                        req_attribute,
   input  logic [1:0]                         req_action_mask,
   input  logic [31:0]                        req_now_tick,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic [2:0]                         rsp_status,
   output logic [3:0]                         rsp_slot,
   output logic [63:0]                        rsp_alarm_addr,
   output logic [7:0]                         rsp_alarm_endpoint,
   output logic [15:0]                        rsp_alarm_cluster,
   output logic [15:0]                        rsp_alarm_attribute,
   output logic                               rsp_send_sms,
   output logic                               rsp_send_email,
   output logic [7:0]                         rsp_sent_number,
   output logic                               rsp_last,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [arl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_data
);

   // fill count reaches the depth itself; memory address is one bit narrower for a power-of-two depth
   localparam int IW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RW = $bits(arl_pkg::rec_type);

   arl_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [7:0]  max_send_ff;
   logic [31:0] latency_ff;

   // entries are appended in slot order and never removed, so slot i is valid iff i < fill
   logic [IW-1:0] fill_ff, fill_in;

   // walk control: idx is the slot being read, cmp the slot whose data is at the memory output
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [4:0]    notes_ff, notes_in;

   // latched request transaction
   logic [1:0]  op_ff;
   logic [63:0] key_ff;
   logic [7:0]  ep_ff;
   logic [15:0] cl_ff;
   logic [15:0] at_ff;
   logic [1:0]  act_ff;
   logic [31:0] now_ff;

   // pending result and output register
   arl_pkg::res_type pend_ff, pend_in;
   arl_pkg::res_type out_ff;
   logic             out_vld_ff;

   // memory ports
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [RW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [RW-1:0] ram_rd_data;

   arl_pkg::rec_type rec;
   arl_pkg::rec_type rec_upd;
   arl_pkg::rec_type rec_new;

   logic        req_accept;
   logic        op_known;
   logic        is_proc;
   logic        key_match;
   logic        due;
   logic        hit;
   logic        scan_end;
   logic        out_free;
   logic        can_insert;
   logic [31:0] elapsed;
   logic [31:0] cmp_wide;
   logic [31:0] fill_wide;

   arl_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   //--------------------------------------------------------------------------------------
   // compare stage: looks at the entry just read from memory
   //--------------------------------------------------------------------------------------
   always_comb begin
      rec        = arl_pkg::rec_type'(ram_rd_data);
      req_accept = req_valid && req_ready;
      op_known   = req_op inside {arl_pkg::OP_SET, arl_pkg::OP_CLEAR, arl_pkg::OP_PROCESS};
      is_proc    = (op_ff == arl_pkg::OP_PROCESS);
      out_free   = !out_vld_ff || rsp_ready;
      can_insert = (fill_ff < IW'(TABLE_DEPTH));
      cmp_wide   = 32'(cmp_idx_ff);
      fill_wide  = 32'(fill_ff);

      key_match = (rec.key == key_ff) && (rec.endpoint == ep_ff)
                  && (rec.cluster == cl_ff) && (rec.attribute == at_ff);

      // 32-bit wrap difference; a tick below the last send time counts as roll-over
      elapsed = now_ff - rec.last_sent;
      due     = rec.on && (rec.send_count < max_send_ff)
                && (!rec.ever_sent || (now_ff < rec.last_sent) || (elapsed > latency_ff));

      hit = (state_ff == arl_pkg::ST_SCAN) && cmp_vld_ff
            && ((!is_proc && key_match) || (is_proc && due));

      // walk ends once every valid slot was compared, or the notice budget is spent
      scan_end = (state_ff == arl_pkg::ST_SCAN) && !cmp_vld_ff
                 && ((idx_ff >= fill_ff) || (is_proc && (notes_ff == arl_pkg::MAX_NOTICES)));
   end

   //--------------------------------------------------------------------------------------
   // next state
   //--------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arl_pkg::ST_IDLE: begin
            if (req_accept && op_known) begin
               state_in = arl_pkg::ST_SCAN;
            end
         end
         arl_pkg::ST_SCAN: begin
            if (hit || scan_end) begin
               state_in = arl_pkg::ST_EMIT;
            end
         end
         arl_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = pend_ff.last ? arl_pkg::ST_IDLE : arl_pkg::ST_SCAN;
            end
         end
         default: state_in = arl_pkg::ST_IDLE;
      endcase
   end

   //--------------------------------------------------------------------------------------
   // datapath control: memory writes, walk counters, pending result
   //--------------------------------------------------------------------------------------
   always_comb begin
      req_ready  = (state_ff == arl_pkg::ST_IDLE);
      ram_rd_en  = (state_ff == arl_pkg::ST_SCAN) && (idx_ff < fill_ff);

      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      notes_in   = notes_ff;
      fill_in    = fill_ff;
      pend_in    = pend_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = cmp_idx_ff[AW-1:0];

      // update of the matched entry
      rec_upd = rec;
      case (op_ff)
         arl_pkg::OP_SET: begin
            rec_upd.action = act_ff;
            rec_upd.on     = 1'b1;
         end
         arl_pkg::OP_CLEAR: begin
            rec_upd.on         = 1'b0;
            rec_upd.send_count = 8'd0;
         end
         default: begin
            rec_upd.last_sent  = now_ff;
            rec_upd.ever_sent  = 1'b1;
            rec_upd.send_count = rec.send_count + 8'd1;
         end
      endcase

      // freshly inserted entry
      rec_new.key        = key_ff;
      rec_new.endpoint   = ep_ff;
      rec_new.cluster    = cl_ff;
      rec_new.attribute  = at_ff;
      rec_new.action     = act_ff;
      rec_new.on         = 1'b1;
      rec_new.send_count = 8'd0;
      rec_new.last_sent  = 32'd0;
      rec_new.ever_sent  = 1'b0;

      ram_wr_data = rec_upd;

      if (state_ff == arl_pkg::ST_IDLE) begin
         idx_in     = '0;
         cmp_vld_in = 1'b0;
         notes_in   = 5'd0;
      end else if (state_ff == arl_pkg::ST_SCAN) begin
         if (hit) begin
            ram_wr_en  = 1'b1;
            // resume behind the hit slot after the result is out
            idx_in     = cmp_idx_ff + IW'(1);
            cmp_vld_in = 1'b0;
            pend_in    = '0;
            pend_in.slot = cmp_wide[3:0];
            if (is_proc) begin
               notes_in               = notes_ff + 5'd1;
               pend_in.kind           = arl_pkg::KIND_NOTICE;
               pend_in.alarm_addr     = rec.key;
               pend_in.alarm_endpoint = rec.endpoint;
               pend_in.alarm_cluster  = rec.cluster;
               pend_in.alarm_attribute = rec.attribute;
               pend_in.send_sms       = rec.action[arl_pkg::ACT_SMS_BIT];
               pend_in.send_email     = rec.action[arl_pkg::ACT_EMAIL_BIT];
               pend_in.sent_number    = rec_upd.send_count;
            end else begin
               pend_in.kind   = arl_pkg::KIND_STATUS;
               pend_in.status = (op_ff == arl_pkg::OP_SET) ? arl_pkg::STAT_UPDATED
                                                           : arl_pkg::STAT_CLEARED;
               pend_in.last   = 1'b1;
            end
         end else if (scan_end) begin
            pend_in      = '0;
            pend_in.kind = arl_pkg::KIND_STATUS;
            pend_in.last = 1'b1;
            case (op_ff)
               arl_pkg::OP_SET: begin
                  if (can_insert) begin
                     ram_wr_en      = 1'b1;
                     ram_wr_addr    = fill_ff[AW-1:0];
                     ram_wr_data    = rec_new;
                     fill_in        = fill_ff + IW'(1);
                     pend_in.status = arl_pkg::STAT_INSERTED;
                     pend_in.slot   = fill_wide[3:0];
                  end else begin
                     pend_in.status = arl_pkg::STAT_FULL;
                  end
               end
               arl_pkg::OP_CLEAR: pend_in.status = arl_pkg::STAT_NOT_FOUND;
               default:           pend_in.status = arl_pkg::STAT_DONE;
            endcase
         end else begin
            // one read per cycle; the compare stage sees the entry read in the following cycle
            cmp_idx_in = idx_ff;
            cmp_vld_in = (idx_ff < fill_ff);
            if (idx_ff < fill_ff) begin
               idx_in = idx_ff + IW'(1);
            end
         end
      end
   end

   //--------------------------------------------------------------------------------------
   // registers
   //--------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= arl_pkg::ST_IDLE;
         max_send_ff <= arl_pkg::MAX_SEND_COUNT_RESET;
         latency_ff  <= arl_pkg::REPEAT_LATENCY_RESET;
         fill_ff     <= '0;
         idx_ff      <= '0;
         cmp_idx_ff  <= '0;
         cmp_vld_ff  <= 1'b0;
         notes_ff    <= 5'd0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         idx_ff     <= idx_in;
         cmp_idx_ff <= cmp_idx_in;
         cmp_vld_ff <= cmp_vld_in;
         notes_ff   <= notes_in;

         if ((state_ff == arl_pkg::ST_EMIT) && out_free) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               arl_pkg::CSR_MAX_SEND_COUNT: max_send_ff <= csr_data[7:0];
               arl_pkg::CSR_REPEAT_LATENCY: latency_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_op;
         key_ff <= req_device_addr;
         ep_ff  <= req_endpoint;
         cl_ff  <= req_cluster;
         at_ff  <= req_attribute;
         act_ff <= req_action_mask;
         now_ff <= req_now_tick;
      end
      pend_ff <= pend_in;
      if ((state_ff == arl_pkg::ST_EMIT) && out_free) begin
         out_ff <= pend_ff;
      end
   end

   // configuration writes complete in the cycle they are offered
   assign csr_ready = 1'b1;

   assign rsp_valid           = out_vld_ff;
   assign rsp_kind            = out_ff.kind;
   assign rsp_status          = out_ff.status;
   assign rsp_slot            = out_ff.slot;
   assign rsp_alarm_addr      = out_ff.alarm_addr;
   assign rsp_alarm_endpoint  = out_ff.alarm_endpoint;
   assign rsp_alarm_cluster   = out_ff.alarm_cluster;
   assign rsp_alarm_attribute = out_ff.alarm_attribute;
   assign rsp_send_sms        = out_ff.send_sms;
   assign rsp_send_email      = out_ff.send_email;
   assign rsp_sent_number     = out_ff.sent_number;
   assign rsp_last            = out_ff.last;

endmodule
